>>> hdl/s2l_pkg.sv
// Shared types, constants and table builders for the sRGB to CIELAB converter.
package s2l_pkg;

	// One input pixel and one converted result.
	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pixel_t;

	typedef struct packed {
		logic        [14:0] lightness;
		logic signed [15:0] green_red_axis;
		logic signed [15:0] blue_yellow_axis;
	} lab_t;

	// Unsigned Q1.16 values and Q0.20 matrix coefficients.
	typedef logic [16:0] q16_t;
	typedef logic [19:0] coef_t;
	typedef q16_t gamma_tab_t [256];

	// Number of clock edges from an accepted request to its result strobe.
	localparam int unsigned PIPE_LATENCY = 8;

	localparam q16_t DARK_LIMIT = 17'd580;
	localparam q16_t LIN_OFFSET = 17'd9039;

	// RGB to XYZ matrix, rows already divided by the D65 white point.
	localparam coef_t COEF_X [3] = '{20'd455026, 20'd394489, 20'd199046};
	localparam coef_t COEF_Y [3] = '{20'd223002, 20'd749899, 20'd75675};
	localparam coef_t COEF_Z [3] = '{20'd18619, 20'd114786, 20'd915097};

	// Fifth power in Q1.31 with truncating products.
	function automatic logic [63:0] pow5_q31(input logic [63:0] r);
		logic [63:0] r2;
		logic [63:0] r4;
		r2 = (r * r) >> 31;
		r4 = (r2 * r2) >> 31;
		return (r4 * r) >> 31;
	endfunction

	// Inverse sRGB gamma of one 8-bit code, rounded to Q1.16.
	function automatic q16_t gamma_entry(input int unsigned c);
		logic [63:0] num;
		logic [63:0] u;
		logic [63:0] s;
		logic [63:0] lo;
		logic [63:0] hi;
		logic [63:0] mid;
		logic [63:0] g;
		if (c * 100000 <= 1031475) begin
			return q16_t'((64'(c) * 64'd1310720 + 64'd32946) / 64'd65892);
		end
		num = 64'(c) * 64'd1000 + 64'd14025;
		u = ((num << 31) + 64'd134512) / 64'd269025;
		s = (u * u + (64'd1 << 30)) >> 31;
		lo = 64'd0;
		hi = 64'd1 << 31;
		// Binary search for the fifth root of u squared.
		while (lo < hi) begin
			mid = (lo + hi + 64'd1) >> 1;
			if (pow5_q31(mid) <= s) lo = mid;
			else hi = mid - 64'd1;
		end
		g = (s * lo) >> 31;
		return q16_t'((g + (64'd1 << 14)) >> 15);
	endfunction

	function automatic gamma_tab_t build_gamma_tab();
		gamma_tab_t tab;
		for (int unsigned c = 0; c < 256; c++) begin
			tab[c] = gamma_entry(c);
		end
		return tab;
	endfunction

	localparam gamma_tab_t GAMMA_TAB = build_gamma_tab();

endpackage

>>> hdl/s2l_gamma.sv
// Stage 1: inverse gamma lookup of the three channels.
module s2l_gamma (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  s2l_pkg::pixel_t pixel,
	output logic           v_s1,
	output s2l_pkg::q16_t  red_s1,
	output s2l_pkg::q16_t  green_s1,
	output s2l_pkg::q16_t  blue_s1
);
	import s2l_pkg::*;

	// Valid bit of the stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else v_s1 <= in_valid;
	end

	// Three reads of the constant gamma table.
	always_ff @(posedge clk) begin
		red_s1   <= GAMMA_TAB[pixel.red];
		green_s1 <= GAMMA_TAB[pixel.green];
		blue_s1  <= GAMMA_TAB[pixel.blue];
	end
endmodule

>>> hdl/s2l_matrix.sv
// Stages 2 and 3: linear RGB to white-normalized XYZ.
module s2l_matrix (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          v_s1,
	input  s2l_pkg::q16_t red_s1,
	input  s2l_pkg::q16_t green_s1,
	input  s2l_pkg::q16_t blue_s1,
	output logic          v_s3,
	output s2l_pkg::q16_t x_s3,
	output s2l_pkg::q16_t y_s3,
	output s2l_pkg::q16_t z_s3
);
	import s2l_pkg::*;

	logic        v_s2;
	logic [36:0] px_s2 [3];
	logic [36:0] py_s2 [3];
	logic [36:0] pz_s2 [3];
	logic [38:0] sx;
	logic [38:0] sy;
	logic [38:0] sz;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Nine products, one per coefficient.
	always_ff @(posedge clk) begin
		px_s2[0] <= red_s1 * COEF_X[0];
		px_s2[1] <= green_s1 * COEF_X[1];
		px_s2[2] <= blue_s1 * COEF_X[2];
		py_s2[0] <= red_s1 * COEF_Y[0];
		py_s2[1] <= green_s1 * COEF_Y[1];
		py_s2[2] <= blue_s1 * COEF_Y[2];
		pz_s2[0] <= red_s1 * COEF_Z[0];
		pz_s2[1] <= green_s1 * COEF_Z[1];
		pz_s2[2] <= blue_s1 * COEF_Z[2];
	end

	// Row sums rounded half up back to Q1.16.
	always_comb begin
		sx = 39'(px_s2[0]) + 39'(px_s2[1]) + 39'(px_s2[2]) + 39'(1 << 19);
		sy = 39'(py_s2[0]) + 39'(py_s2[1]) + 39'(py_s2[2]) + 39'(1 << 19);
		sz = 39'(pz_s2[0]) + 39'(pz_s2[1]) + 39'(pz_s2[2]) + 39'(1 << 19);
	end

	always_ff @(posedge clk) begin
		x_s3 <= sx[36:20];
		y_s3 <= sy[36:20];
		z_s3 <= sz[36:20];
	end
endmodule

>>> hdl/s2l_lab_f.sv
// Stages 4 to 6: the CIELAB f function of one channel, plus the dark-region L value.
module s2l_lab_f #(
	parameter int ROOT_TABLE_DEPTH = 1024
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          v_s3,
	input  s2l_pkg::q16_t t_s3,
	output logic          v_s6,
	output s2l_pkg::q16_t f_s6,
	output logic          dark_s6,
	output logic [19:0]   ldark_s6
);
	import s2l_pkg::*;

	localparam int AW = $clog2(ROOT_TABLE_DEPTH);
	localparam int PW = 17 + AW + 1;
	localparam logic [AW-1:0] SPAN = AW'(ROOT_TABLE_DEPTH - 1);

	typedef q16_t root_tab_t [ROOT_TABLE_DEPTH];

	// Entry i holds the rounded Q1.16 cube root of i over the table span.
	function automatic root_tab_t build_root_tab();
		root_tab_t   tab;
		logic [63:0] target;
		logic [63:0] lo;
		logic [63:0] hi;
		logic [63:0] mid;
		for (int i = 0; i < ROOT_TABLE_DEPTH; i++) begin
			target = 64'(i) << 51;
			lo = 64'd0;
			hi = 64'd1 << 17;
			while (lo < hi) begin
				mid = (lo + hi + 64'd1) >> 1;
				if (mid * mid * mid * 64'(ROOT_TABLE_DEPTH - 1) <= target) lo = mid;
				else hi = mid - 64'd1;
			end
			tab[i] = q16_t'((lo + 64'd1) >> 1);
		end
		return tab;
	endfunction

	localparam root_tab_t ROOT_TAB = build_root_tab();

	logic          v_s4;
	logic          v_s5;
	logic          dark_s4;
	logic          dark_s5;
	logic [AW-1:0] idx_s4;
	logic [22:0]   lin_n_s4;
	logic [23:0]   ld_n_s4;
	q16_t          root_s5;
	logic [22:0]   lin_n_s5;
	logic [23:0]   ld_n_s5;
	logic [12:0]   lin_q_s5;
	logic [19:0]   ld_q_s5;
	logic [PW-1:0] idx_sum;
	logic [AW+1:0] idx_full;
	logic [9:0]    t_lo;
	logic [44:0]   lin_prod;
	logic [42:0]   ld_prod;
	logic [22:0]   lin_rem;
	logic [23:0]   ld_rem;
	logic [12:0]   lin_q;
	logic [19:0]   ld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// Root table address, and numerators of the linear segment and dark L.
	// In the dark region t fits in ten bits.
	always_comb begin
		idx_sum  = PW'(t_s3) * PW'(SPAN) + PW'(32768);
		idx_full = idx_sum[PW-1:16];
		t_lo     = t_s3[9:0];
	end

	always_ff @(posedge clk) begin
		dark_s4  <= (t_s3 <= DARK_LIMIT);
		idx_s4   <= (idx_full > (AW+2)'(SPAN)) ? SPAN : idx_full[AW-1:0];
		lin_n_s4 <= 23'(t_lo) * 23'd7787 + 23'd500;
		ld_n_s4  <= 24'(t_lo) * 24'd9033;
	end

	// Registered table read; reciprocal estimates of the divisions by 1000 and 10.
	always_comb begin
		lin_prod = 45'(lin_n_s4) * 45'd4194;
		ld_prod  = 43'(ld_n_s4) * 43'd419430;
	end

	always_ff @(posedge clk) begin
		root_s5  <= ROOT_TAB[idx_s4];
		dark_s5  <= dark_s4;
		lin_n_s5 <= lin_n_s4;
		ld_n_s5  <= ld_n_s4;
		lin_q_s5 <= lin_prod[34:22];
		ld_q_s5  <= ld_prod[41:22];
	end

	// The estimates are low by at most one: a single compare fixes them.
	always_comb begin
		lin_rem = lin_n_s5 - 23'(lin_q_s5) * 23'd1000;
		ld_rem  = ld_n_s5 - 24'(ld_q_s5) * 24'd10;
		lin_q   = (lin_rem >= 23'd1000) ? lin_q_s5 + 13'd1 : lin_q_s5;
		ld_q    = (ld_rem >= 24'd10) ? ld_q_s5 + 20'd1 : ld_q_s5;
	end

	// The dark L value reaches about eight in Q.16, so it fits in nineteen of the twenty bits.
	always_ff @(posedge clk) begin
		f_s6     <= dark_s5 ? 17'(lin_q) + LIN_OFFSET : root_s5;
		dark_s6  <= dark_s5;
		ldark_s6 <= ld_q;
	end
endmodule

>>> hdl/s2l_output.sv
// Stages 7 and 8: L, a and b assembly, output rounding and saturation.
module s2l_output #(
	parameter int OUT_FRAC_BITS = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          v_s6,
	input  s2l_pkg::q16_t fx_s6,
	input  s2l_pkg::q16_t fy_s6,
	input  s2l_pkg::q16_t fz_s6,
	input  logic          dark_s6,
	input  logic [19:0]   ldark_s6,
	output logic          done,
	output s2l_pkg::lab_t lab
);
	import s2l_pkg::*;

	localparam int SH = 16 - OUT_FRAC_BITS;
	localparam logic [27:0] HALF = 28'(1) << (SH - 1);

	logic               v_s7;
	logic signed [27:0] l_s7;
	logic signed [27:0] a_s7;
	logic signed [27:0] b_s7;
	logic signed [17:0] dxy;
	logic signed [17:0] dyz;
	logic signed [27:0] l_r;
	logic signed [27:0] a_r;
	logic signed [27:0] b_r;

	// Symmetric rounding from 16 fraction bits to the output fraction.
	function automatic logic signed [27:0] round_out(input logic signed [27:0] v);
		logic [27:0] mag;
		logic [27:0] rm;
		mag = v[27] ? 28'(-v) : 28'(v);
		rm  = (mag + HALF) >> SH;
		return v[27] ? -$signed(rm) : $signed(rm);
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [27:0] v);
		if (v > 28'sd32767) return 16'sh7fff;
		if (v < -28'sd32768) return 16'sh8000;
		return v[15:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
			done <= 1'b0;
		end else begin
			v_s7 <= v_s6;
			done <= v_s7;
		end
	end

	// Scaled L, a and b in 16 fraction bits.
	always_comb begin
		dxy = $signed({1'b0, fx_s6}) - $signed({1'b0, fy_s6});
		dyz = $signed({1'b0, fy_s6}) - $signed({1'b0, fz_s6});
	end

	always_ff @(posedge clk) begin
		l_s7 <= dark_s6 ? $signed(28'(ldark_s6))
			: $signed(28'(fy_s6)) * 28'sd116 - 28'sd1048576;
		a_s7 <= 28'(dxy) * 28'sd500;
		b_s7 <= 28'(dyz) * 28'sd200;
	end

	always_comb begin
		l_r = round_out(l_s7);
		a_r = round_out(a_s7);
		b_r = round_out(b_s7);
	end

	// L is clamped to its unsigned field, a and b to 16-bit two's complement.
	always_ff @(posedge clk) begin
		if (l_r < 28'sd0) lab.lightness <= 15'd0;
		else if (l_r > 28'sd32767) lab.lightness <= 15'h7fff;
		else lab.lightness <= l_r[14:0];
		lab.green_red_axis   <= sat16(a_r);
		lab.blue_yellow_axis <= sat16(b_r);
	end
endmodule

>>> hdl/srgb_to_cielab_convert_unit.sv
// Top level of the sRGB to CIELAB (D65) converter.
// Converts one 8-bit sRGB pixel to CIELAB L, a and b with OUT_FRAC_BITS fraction bits.
// A request is taken on every clock edge at which start is high; busy never rises, so
// a new pixel may be issued every cycle. Each result appears on lab for one cycle,
// flagged by done, in request order. The eight stages are the gamma table, the matrix
// products, the matrix sums, three stages of the f function (address, cube-root table
// read, linear-segment correction), the L/a/b scaling and the output rounding. The
// receiver cannot hold results back.
module srgb_to_cielab_convert_unit #(
	parameter int OUT_FRAC_BITS    = 8,
	parameter int ROOT_TABLE_DEPTH = 1024
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  s2l_pkg::pixel_t pixel,
	output logic            done,
	output s2l_pkg::lab_t   lab
);
	import s2l_pkg::*;

	logic        v_s1;
	logic        v_s3;
	logic        vx_s6;
	logic        vy_s6;
	logic        vz_s6;
	q16_t        red_s1;
	q16_t        green_s1;
	q16_t        blue_s1;
	q16_t        x_s3;
	q16_t        y_s3;
	q16_t        z_s3;
	q16_t        fx_s6;
	q16_t        fy_s6;
	q16_t        fz_s6;
	logic        dy_s6;
	logic [19:0] ldark_s6;
	logic        unused_dx;
	logic        unused_dz;
	logic [19:0] unused_lx;
	logic [19:0] unused_lz;

	// The pipeline never stalls.
	assign busy = 1'b0;

	s2l_gamma u_gamma (
		.clk, .arst_n,
		.in_valid (start & ~busy),
		.pixel,
		.v_s1, .red_s1, .green_s1, .blue_s1
	);

	s2l_matrix u_matrix (
		.clk, .arst_n,
		.v_s1, .red_s1, .green_s1, .blue_s1,
		.v_s3, .x_s3, .y_s3, .z_s3
	);

	s2l_lab_f #(.ROOT_TABLE_DEPTH(ROOT_TABLE_DEPTH)) u_fx (
		.clk, .arst_n, .v_s3, .t_s3(x_s3),
		.v_s6(vx_s6), .f_s6(fx_s6), .dark_s6(unused_dx), .ldark_s6(unused_lx)
	);

	s2l_lab_f #(.ROOT_TABLE_DEPTH(ROOT_TABLE_DEPTH)) u_fy (
		.clk, .arst_n, .v_s3, .t_s3(y_s3),
		.v_s6(vy_s6), .f_s6(fy_s6), .dark_s6(dy_s6), .ldark_s6(ldark_s6)
	);

	s2l_lab_f #(.ROOT_TABLE_DEPTH(ROOT_TABLE_DEPTH)) u_fz (
		.clk, .arst_n, .v_s3, .t_s3(z_s3),
		.v_s6(vz_s6), .f_s6(fz_s6), .dark_s6(unused_dz), .ldark_s6(unused_lz)
	);

	s2l_output #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_out (
		.clk, .arst_n,
		.v_s6     (vx_s6 & vy_s6 & vz_s6),
		.fx_s6, .fy_s6, .fz_s6,
		.dark_s6  (dy_s6),
		.ldark_s6,
		.done, .lab
	);
endmodule

>>> hdl/s2l_checker.sv
// Port-level checks of the converter, bound to its top level.
module s2l_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            start,
	input logic            busy,
	input s2l_pkg::pixel_t pixel,
	input logic            done,
	input s2l_pkg::lab_t   lab
);
	import s2l_pkg::*;

	// Every request produces its result a fixed latency later.
	assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##PIPE_LATENCY done)
		else $error("request produced no result");

	// No result without a request a fixed latency earlier.
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, PIPE_LATENCY))
		else $error("result without a request");

	// A black pixel converts to L, a and b all zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		done && $past(pixel == '0, PIPE_LATENCY) |-> lab == '0)
		else $error("black pixel gave a nonzero result");

	// A gray pixel has no green-red chroma beyond rounding.
	assert property (@(posedge clk) disable iff (!arst_n)
		done && $past(pixel.red == pixel.green && pixel.green == pixel.blue, PIPE_LATENCY)
		|-> lab.green_red_axis < 16'sd256 && lab.green_red_axis > -16'sd256)
		else $error("gray pixel gave large chroma");
endmodule

bind srgb_to_cielab_convert_unit s2l_checker u_s2l_checker (.*);

>>> dv/tb.sv
// Self-checking testbench for the sRGB to CIELAB converter, with its own bit-exact predictor.
module tb;
	import s2l_pkg::*;

	localparam int FRAC_BITS = 8;
	localparam int ROOT_DEPTH = 1024;
	localparam int CYCLE_LIMIT = 200000;

	logic   clk;
	logic   arst_n;
	logic   start;
	logic   busy;
	pixel_t pixel;
	logic   done;
	lab_t   lab;

	srgb_to_cielab_convert_unit #(
		.OUT_FRAC_BITS(FRAC_BITS),
		.ROOT_TABLE_DEPTH(ROOT_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.pixel(pixel),
		.done(done),
		.lab(lab)
	);

	// Own copies of the two lookup tables.
	logic [16:0] linear_of_code [256];
	logic [16:0] cube_root_of [ROOT_DEPTH];

	lab_t lab_expected [$];
	int   error_count;
	int   cycle_count;
	int   pixel_count;
	int   idle_percent;
	logic busy_seen;

	// Clock.
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Watchdog on total run length.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("simulation failed");
			$finish;
		end
	end

	// Truncating Q1.31 fifth power.
	function automatic longint unsigned fifth_power(input longint unsigned r);
		longint unsigned sq;
		longint unsigned quad;
		sq = (r * r) >> 31;
		quad = (sq * sq) >> 31;
		return (quad * r) >> 31;
	endfunction

	// Linear light of one sRGB code in Q1.16.
	function automatic logic [16:0] decode_gamma(input int unsigned code);
		longint unsigned base;
		longint unsigned sq;
		longint unsigned low_b;
		longint unsigned high_b;
		longint unsigned probe;
		longint unsigned prod;
		if (code * 100000 <= 1031475)
			return 17'((longint'(code) * 1310720 + 32946) / 65892);
		base = ((longint'(code) * 1000 + 14025) << 31);
		base = (base + 134512) / 269025;
		sq = (base * base + (64'd1 << 30)) >> 31;
		low_b = 0;
		high_b = 64'd1 << 31;
		while (low_b < high_b) begin
			probe = (low_b + high_b + 1) >> 1;
			if (fifth_power(probe) <= sq) low_b = probe;
			else high_b = probe - 1;
		end
		prod = (sq * low_b) >> 31;
		return 17'((prod + (64'd1 << 14)) >> 15);
	endfunction

	// Rounded cube root of idx/(depth-1) in Q1.16.
	function automatic logic [16:0] cube_root_entry(input longint unsigned idx);
		longint unsigned goal;
		longint unsigned low_b;
		longint unsigned high_b;
		longint unsigned probe;
		goal = idx << 51;
		low_b = 0;
		high_b = 64'd1 << 17;
		while (low_b < high_b) begin
			probe = (low_b + high_b + 1) >> 1;
			if (probe * probe * probe * (ROOT_DEPTH - 1) <= goal) low_b = probe;
			else high_b = probe - 1;
		end
		return 17'((low_b + 1) >> 1);
	endfunction

	// Weighted channel sum, Q1.16 times Q0.20, round half up.
	function automatic longint unsigned mix_row(input longint unsigned k0, k1, k2,
			input longint unsigned r, g, b);
		return (k0 * r + k1 * g + k2 * b + (64'd1 << 19)) >> 20;
	endfunction

	// CIELAB companding function: cube root above the dark limit, else linear.
	function automatic longint lab_compand(input longint unsigned t);
		longint unsigned addr;
		if (t > 580) begin
			addr = (t * (ROOT_DEPTH - 1) + 32768) >> 16;
			if (addr > ROOT_DEPTH - 1) addr = ROOT_DEPTH - 1;
			return longint'(cube_root_of[addr]);
		end
		return longint'((t * 7787 + 500) / 1000 + 9039);
	endfunction

	// Reduce Q.16 to output fraction bits, rounding half away from zero.
	function automatic longint narrow(input longint v);
		longint unsigned half;
		half = 64'd1 << (16 - FRAC_BITS - 1);
		if (v >= 0) return longint'((longint'(v) + half) >> (16 - FRAC_BITS));
		return -longint'((longint'(-v) + half) >> (16 - FRAC_BITS));
	endfunction

	function automatic logic [15:0] clip_s16(input longint v);
		if (v > 32767) v = 32767;
		if (v < -32768) v = -32768;
		return v[15:0];
	endfunction

	// Expected CIELAB result for one pixel.
	function automatic lab_t convert_pixel(input pixel_t p);
		longint unsigned r, g, b, x, y, z;
		longint fx, fy, fz, l16, l;
		lab_t res;
		r = linear_of_code[p.red];
		g = linear_of_code[p.green];
		b = linear_of_code[p.blue];
		x = mix_row(455026, 394489, 199046, r, g, b);
		y = mix_row(223002, 749899, 75675, r, g, b);
		z = mix_row(18619, 114786, 915097, r, g, b);
		fx = lab_compand(x);
		fy = lab_compand(y);
		fz = lab_compand(z);
		if (y > 580) l16 = 116 * fy - 16 * 65536;
		else l16 = longint'((y * 9033) / 10);
		l = narrow(l16);
		if (l < 0) l = 0;
		if (l > 32767) l = 32767;
		res.lightness = l[14:0];
		res.green_red_axis = clip_s16(narrow(500 * (fx - fy)));
		res.blue_yellow_axis = clip_s16(narrow(200 * (fy - fz)));
		return res;
	endfunction

	task automatic report_mismatch(input string what);
		$display("mismatch at cycle %0d: %s", cycle_count, what);
		error_count++;
	endtask

	// Busy only changes at the rising edge, so the falling-edge value is the one seen there.
	always @(negedge clk) busy_seen <= busy;

	// Compare each result strobe with the oldest pending conversion.
	always @(negedge clk) begin
		lab_t want;
		if (arst_n && done) begin
			if (lab_expected.size() == 0) begin
				report_mismatch("result with no pending request");
			end else begin
				want = lab_expected.pop_front();
				if (lab.lightness !== want.lightness)
					report_mismatch($sformatf("L got %0d want %0d",
						lab.lightness, want.lightness));
				if (lab.green_red_axis !== want.green_red_axis)
					report_mismatch($sformatf("a got %0d want %0d",
						lab.green_red_axis, want.green_red_axis));
				if (lab.blue_yellow_axis !== want.blue_yellow_axis)
					report_mismatch($sformatf("b got %0d want %0d",
						lab.blue_yellow_axis, want.blue_yellow_axis));
			end
		end
	end

	// Issue one request, idling beforehand at the current rate.
	task automatic send_pixel(input pixel_t p);
		if ($urandom_range(99) < idle_percent) begin
			start <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
		start <= 1'b1;
		pixel <= p;
		do @(posedge clk); while (busy_seen);
		lab_expected.push_back(convert_pixel(p));
		pixel_count++;
	endtask

	task automatic send_rgb(input int r, g, b);
		pixel_t p;
		p.red = r[7:0];
		p.green = g[7:0];
		p.blue = b[7:0];
		send_pixel(p);
	endtask

	// Hold off until every pending result has come back.
	task automatic wait_drained();
		start <= 1'b0;
		@(posedge clk);
		while (lab_expected.size() != 0) @(posedge clk);
	endtask

	// Extremes, primaries, secondaries, gamma knee codes, dark greys and mixed colours.
	task automatic test_directed();
		idle_percent = 0;
		send_rgb(0, 0, 0);
		send_rgb(255, 255, 255);
		send_rgb(255, 0, 0);
		send_rgb(0, 255, 0);
		send_rgb(0, 0, 255);
		send_rgb(255, 255, 0);
		send_rgb(0, 255, 255);
		send_rgb(255, 0, 255);
		send_rgb(10, 10, 10);
		send_rgb(11, 11, 11);
		send_rgb(1, 1, 1);
		send_rgb(24, 24, 24);
		send_rgb(25, 25, 25);
		send_rgb(128, 128, 128);
		send_rgb(0, 0, 1);
		send_rgb(1, 0, 0);
		send_rgb(254, 254, 254);
		send_rgb(170, 85, 0);
		send_rgb(85, 170, 255);
		send_rgb(0, 10, 255);
	endtask

	// Random pixels, with a share of dark and saturated ones.
	task automatic test_random(input int count, input int idle_rate);
		idle_percent = idle_rate;
		repeat (count) begin
			case ($urandom_range(3))
				0: send_rgb($urandom_range(30), $urandom_range(30), $urandom_range(30));
				1: send_rgb($urandom_range(1) * 255, $urandom_range(255),
					$urandom_range(1) * 255);
				default: send_rgb($urandom_range(255), $urandom_range(255),
					$urandom_range(255));
			endcase
		end
	endtask

	// A sweep over the code range in steps of three, mixed across channels, back to back.
	task automatic test_channel_sweep();
		idle_percent = 0;
		for (int c = 0; c < 256; c += 3) send_rgb(c, 255 - c, c ^ 8'h5a);
	endtask

	initial begin
		error_count = 0;
		cycle_count = 0;
		pixel_count = 0;
		idle_percent = 0;
		arst_n = 1'b0;
		start = 1'b0;
		pixel = '0;
		for (int c = 0; c < 256; c++) linear_of_code[c] = decode_gamma(c);
		for (int i = 0; i < ROOT_DEPTH; i++) cube_root_of[i] = cube_root_entry(i);
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		wait_drained();
		test_random(150, 0);
		test_random(150, 70);
		wait_drained();
		test_channel_sweep();
		test_random(200, 19);

		wait_drained();
		repeat (PIPE_LATENCY + 4) @(posedge clk);
		$display("converted %0d pixels: extremes, primaries, dark greys, sweep, random",
			pixel_count);
		$display("idle rates 0, 70 and 19 percent; %0d mismatches", error_count);
		if (error_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

>>> sim.f
hdl/s2l_pkg.sv
hdl/s2l_gamma.sv
hdl/s2l_matrix.sv
hdl/s2l_lab_f.sv
hdl/s2l_output.sv
hdl/srgb_to_cielab_convert_unit.sv
hdl/s2l_checker.sv
dv/tb.sv
